// ===== hw/rtl/psfd_pkg.sv =====
// Package for the particulate sensor frame decoder: frame constants, mode and
// kind codes, and the CRC-8 byte step. No dependencies.
package psfd_pkg;

    localparam int LONG_FRAME_BYTES  = 30;
    localparam int SHORT_FRAME_BYTES = 12;

    localparam int POS_W = 5;

    localparam logic [7:0]  CRC_INIT  = 8'hFF;
    localparam logic [7:0]  CRC_POLY  = 8'h31;
    localparam logic [15:0] WORD_FAIL = 16'hFFFF;

    // decode_mode register codes
    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_PLAIN   = 2'd1;
    localparam logic [1:0] MODE_CHECKED = 2'd2;
    localparam logic [1:0] MODE_DETECT  = 2'd3;

    // sensor_kind codes in detect mode
    localparam logic [1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [1:0] KIND_PLAIN   = 2'd1;
    localparam logic [1:0] KIND_CRC     = 2'd2;

    // byte roles inside a word slot
    localparam logic [1:0] ROLE_HIGH = 2'd0;
    localparam logic [1:0] ROLE_LOW  = 2'd1;
    localparam logic [1:0] ROLE_CRC  = 2'd2;

    // word slot index; WORD_NONE marks offsets outside any word
    localparam logic [1:0] WORD_NONE = 2'd3;

    typedef logic [15:0] t_word;

    // Eight MSB-first shifts of CRC-8; unrolls to a small XOR network.
    function automatic logic [7:0] crc8_step(input logic [7:0] c_in);
        logic [7:0] c;
        c = c_in;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/pm_sensor_frame_decoder.sv =====
// Particulate sensor frame decoder top level: byte stream in, PM word result out.
// Depends on psfd_pkg.
//
// Takes the sensor response one byte per word on the slave stream, with tuser
// flagging the first byte of a frame, and emits one result word per completed
// frame: PM1, PM2.5 and PM10 (big-endian words at byte offsets 0, 3 and 9),
// a read_ok flag and a sensor kind. decode_mode selects plain 12-byte frames,
// CRC-checked 30-byte frames (CRC-8, poly 0x31, init 0xFF, byte after each word;
// a failing word reads 0xFFFF) or 30-byte detect frames; with no mode set a
// frame start byte yields a failed result and other bytes are dropped. Bytes
// past the frame length are dropped until the next start flag. Throughput is
// one byte per clock while the result stream does not stall; the result word
// passes through the input register, then the result register. The per-byte
// CRC step is XOR logic between the input register and the frame state.
// Write decode_mode only while the block is idle.
module pm_sensor_frame_decoder
    import psfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration: decode_mode
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,

    // byte stream in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tuser,   // [0] frame_start

    // result stream out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata    // [15:0] pm1_value, [31:16] pm25_value,
                                     // [47:32] pm10_value, [48] read_ok,
                                     // [50:49] sensor_kind, [55:51] zero
);

    localparam logic [POS_W-1:0] LEN_LONG  = POS_W'(LONG_FRAME_BYTES);
    localparam logic [POS_W-1:0] LEN_SHORT = POS_W'(SHORT_FRAME_BYTES);

    // configuration
    logic [1:0] r_mode;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    // frame state
    logic [POS_W-1:0] r_pos,  n_pos;
    logic [7:0]       r_crc,  n_crc;
    logic [7:0]       r_hi  [3];
    logic [7:0]       n_hi  [3];
    t_word            r_words [3];
    t_word            n_words [3];
    logic [2:0]       r_good, n_good;
    logic             r_nz,   n_nz;

    // result register
    logic        r_out_valid;
    logic [55:0] r_out_data, n_out_data;
    logic        n_emit;

    logic advance;
    logic work;

    // working values after an optional frame clear
    logic [POS_W-1:0] pos_e;
    logic [7:0]       crc_e;
    logic [4:0]       len;
    logic [1:0]       slot;
    logic [1:0]       role;
    t_word            v [3];
    logic [1:0]       kind;
    logic             ok;

    assign o_cfg_ready = 1'b1;
    assign advance     = !r_out_valid || i_m_tready;
    assign o_s_tready  = !r_in_valid || advance;
    assign work        = r_in_valid && advance;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    always_comb begin
        pos_e = r_in_start ? '0 : r_pos;
        crc_e = r_in_start ? CRC_INIT : r_crc;
        len   = (r_mode == MODE_PLAIN) ? LEN_SHORT : LEN_LONG;

        // offset to word slot and role
        slot = WORD_NONE;
        role = ROLE_HIGH;
        if (pos_e <= POS_W'(2)) begin
            slot = 2'd0;
            role = pos_e[1:0];
        end else if (pos_e <= POS_W'(5)) begin
            slot = 2'd1;
            role = 2'(pos_e - POS_W'(3));
        end else if (pos_e >= POS_W'(9) && pos_e <= POS_W'(11)) begin
            slot = 2'd2;
            role = 2'(pos_e - POS_W'(9));
        end

        // defaults: hold, or take the cleared frame when a start byte arrives
        n_pos  = pos_e;
        n_crc  = crc_e;
        n_good = r_in_start ? 3'b000 : r_good;
        n_nz   = r_in_start ? 1'b0 : r_nz;
        for (int i = 0; i < 3; i++) begin
            n_hi[i]    = r_in_start ? 8'h00 : r_hi[i];
            n_words[i] = r_in_start ? 16'h0000 : r_words[i];
        end
        n_emit     = 1'b0;
        n_out_data = '0;

        if (r_mode == MODE_NONE) begin
            n_emit = r_in_start;
        end else if (pos_e < len) begin
            if (r_in_byte != 8'h00) begin
                n_nz = 1'b1;
            end
            if (slot != WORD_NONE) begin
                case (role)
                    ROLE_HIGH: begin
                        n_hi[slot] = r_in_byte;
                        n_crc      = crc8_step(CRC_INIT ^ r_in_byte);
                    end
                    ROLE_LOW: begin
                        n_words[slot] = {n_hi[slot], r_in_byte};
                        n_crc         = crc8_step(crc_e ^ r_in_byte);
                    end
                    ROLE_CRC: begin
                        if (crc_e == r_in_byte) begin
                            n_good[slot] = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            n_pos  = pos_e + POS_W'(1);
            n_emit = (n_pos == len);
        end

        // result fields from the updated frame state
        for (int i = 0; i < 3; i++) begin
            v[i] = n_words[i];
            if (r_mode == MODE_CHECKED && !n_good[i]) begin
                v[i] = WORD_FAIL;
            end
        end
        if (r_mode == MODE_DETECT) begin
            if (n_nz && (n_good[1:0] != 2'b00)) begin
                kind = KIND_CRC;
            end else if (v[0] != 16'h0000 || v[1] != 16'h0000 || v[2] != 16'h0000) begin
                kind = KIND_PLAIN;
            end else begin
                kind = KIND_UNKNOWN;
            end
        end else begin
            kind = r_mode;
        end
        ok = (v[0] != WORD_FAIL) && (v[1] != WORD_FAIL) && (v[2] != WORD_FAIL);

        if (r_mode != MODE_NONE) begin
            n_out_data = {5'b00000, kind, ok, v[2], v[1], v[0]};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NONE;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_crc       <= CRC_INIT;
            r_good      <= 3'b000;
            r_nz        <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_hi[i]    <= 8'h00;
                r_words[i] <= 16'h0000;
            end
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= work && n_emit;
            end
            if (work) begin
                r_pos  <= n_pos;
                r_crc  <= n_crc;
                r_good <= n_good;
                r_nz   <= n_nz;
                for (int i = 0; i < 3; i++) begin
                    r_hi[i]    <= n_hi[i];
                    r_words[i] <= n_words[i];
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_in_byte  <= i_s_tdata;
            r_in_start <= i_s_tuser;
        end
        if (work && n_emit) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
